@@ rtl/core/pcf_pkg.sv @@
package pcf_pkg;

  localparam int unsigned CORDIC_ITER_DEF = 16;
  localparam int unsigned CORDIC_MAX      = 24;
  localparam int unsigned SQRT_STEPS      = 24;
  localparam int unsigned DIV_STEPS       = 5;
  localparam int unsigned QDEPTH          = 2;

  localparam logic [16:0] ALPHA_RST   = 17'd64225;
  localparam logic [19:0] MAX_DT_RST  = 20'd100000;
  localparam logic [19:0] FB_DT_RST   = 20'd10000;
  localparam logic [16:0] ALPHA_ONE   = 17'd65536;
  // gyro increment = round(|gy| * dt * 512 / 128125), via floor(2^44 / 128125)
  localparam logic [27:0] GYRO_RECIP  = 28'd137304866;
  localparam logic [16:0] GYRO_DEN    = 17'd128125;
  localparam logic [43:0] GYRO_RND    = 44'd64062;
  localparam logic [23:0] DEN_MIN     = 24'd52;
  localparam logic signed [24:0] PITCH_LIM = 25'sd5898240;
  localparam logic signed [32:0] ANGLE_MAX = 33'sd16777215;
  localparam logic signed [32:0] ANGLE_MIN = -33'sd16777216;

  localparam logic KIND_INIT   = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  localparam logic [1:0] REG_ALPHA  = 2'd0;
  localparam logic [1:0] REG_MAX_DT = 2'd1;
  localparam logic [1:0] REG_FB_DT  = 2'd2;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_y;
    logic [19:0]        dt_us;
  } pcf_job_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } pcf_back_stat_t;

  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/pcf_if.sv @@
interface pcf_in_if;
  import pcf_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_y;
  logic [31:0]        time_us;
  modport source (output valid, kind, accel_x, accel_y, accel_z, gyro_y, time_us,
                  input ready);
  modport sink (input valid, kind, accel_x, accel_y, accel_z, gyro_y, time_us,
                output ready);
endinterface

interface pcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] fused_pitch;
  logic signed [23:0] accel_pitch;
  modport source (output valid, fused_pitch, accel_pitch, input ready);
  modport sink (input valid, fused_pitch, accel_pitch, output ready);
endinterface

@@ rtl/core/pcf_front.sv @@
module pcf_front
  import pcf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pcf_in_if.sink      in_ch,
  input  logic [19:0] max_dt_i,
  input  logic [19:0] fb_dt_i,
  input  logic        q_full_i,
  output logic        push_o,
  output pcf_job_t    job_o
);

  logic [31:0] prev_time_q, prev_time_d;
  logic [31:0] diff;
  logic [19:0] dt;

  assign in_ch.ready = !q_full_i;
  assign push_o      = in_ch.valid && !q_full_i;
  assign diff        = in_ch.time_us - prev_time_q;

  always_comb begin
    if (prev_time_q == 32'd0) begin
      dt = 20'd0;
    end else if (diff > {12'd0, max_dt_i}) begin
      dt = fb_dt_i;
    end else begin
      dt = diff[19:0];
    end
  end

  always_comb begin
    prev_time_d = prev_time_q;
    if (push_o && in_ch.kind == KIND_UPDATE) begin
      prev_time_d = in_ch.time_us;
    end
  end

  assign job_o = '{kind: in_ch.kind, accel_x: in_ch.accel_x, accel_y: in_ch.accel_y,
                   accel_z: in_ch.accel_z, gyro_y: in_ch.gyro_y, dt_us: dt};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= 32'd0;
    end else begin
      prev_time_q <= prev_time_d;
    end
  end

endmodule

@@ rtl/core/pcf_queue.sv @@
module pcf_queue
  import pcf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pcf_job_t data_i,
  input  logic     pop_i,
  output pcf_job_t data_o,
  output logic     full_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = $clog2(QDEPTH);
  localparam int unsigned CntW = $clog2(QDEPTH + 1);

  pcf_job_t            entry_q [QDEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = cnt_q == CntW'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/pcf_back.sv @@
module pcf_back
  import pcf_pkg::*;
#(
  parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  pcf_job_t       q_data_i,
  input  logic [16:0]    alpha_i,
  output pcf_back_stat_t stat_o,
  pcf_out_if.source      out_ch
);

  localparam int unsigned CSteps = (CORDIC_ITERATIONS > CORDIC_MAX) ? CORDIC_MAX
                                                                    : CORDIC_ITERATIONS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQA  = 4'd1;
  localparam logic [3:0] ST_SQB  = 4'd2;
  localparam logic [3:0] ST_GYR  = 4'd3;
  localparam logic [3:0] ST_SQRT = 4'd4;
  localparam logic [3:0] ST_CORD = 4'd5;
  localparam logic [3:0] ST_MUL1 = 4'd6;
  localparam logic [3:0] ST_MUL2 = 4'd7;
  localparam logic [3:0] ST_SUM  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0]          state_q, state_d;
  pcf_job_t            job_q, job_d;
  logic [4:0]          cnt_q, cnt_d, dcnt_q, dcnt_d;
  logic [31:0]         sqa_q, sqa_d;
  logic [47:0]         rad_q, rad_d;
  logic [24:0]         srem_q, srem_d;
  logic [23:0]         root_q, root_d;
  logic [43:0]         gu_q, gu_d;
  logic [49:0]         gpl_q, gpl_d;
  logic [49:0]         gph_q, gph_d;
  logic [43:0]         gprod_q, gprod_d;
  logic [27:0]         dq_q, dq_d;
  logic signed [26:0]  cx_q, cx_d, cy_q, cy_d;
  logic signed [24:0]  cz_q, cz_d;
  logic signed [23:0]  acc_q, acc_d;
  logic signed [24:0]  pitch_q, pitch_d;
  logic signed [47:0]  m1_q, m1_d;
  logic signed [41:0]  m2_q, m2_d;
  logic                ovalid_q, ovalid_d;
  logic signed [24:0]  ofused_q, ofused_d;
  logic signed [23:0]  oacc_q, oacc_d;

  logic [31:0] sq_sum;
  logic [15:0] gy_mag;
  logic [34:0] gmag;
  logic [71:0] gsum;
  logic [43:0] grem;
  logic [26:0] st, strial, sdiff;
  logic        sge;
  logic signed [26:0] xs, ys;
  logic signed [24:0] atan_v;
  logic signed [23:0] acc_c;
  logic [16:0] a_eff, a_inv;
  logic signed [28:0] inc;
  logic signed [29:0] g;
  logic signed [48:0] bsum;
  logic signed [32:0] bsh;
  logic        out_free;

  assign out_free = !ovalid_q || out_ch.ready;

  always_comb begin
    sq_sum   = sqa_q + 32'(job_q.accel_z * job_q.accel_z);
    gy_mag   = job_q.gyro_y[15] ? 16'(-job_q.gyro_y) : job_q.gyro_y;
    gmag     = 35'(gy_mag) * 35'(job_q.dt_us);
    gsum     = {gph_q, 22'd0} + 72'(gpl_q);
    grem     = gu_q - gprod_q;

    st     = {srem_q, rad_q[47:46]};
    strial = {1'b0, root_q, 2'b01};
    sge    = st >= strial;
    sdiff  = st - strial;

    xs     = cx_q >>> cnt_q;
    ys     = cy_q >>> cnt_q;
    atan_v = $signed({3'd0, atan_q16(cnt_q)});

    if (job_q.accel_x == 16'sd0) begin
      acc_c = 24'sd0;
    end else if (cz_q > PITCH_LIM) begin
      acc_c = 24'(PITCH_LIM);
    end else if (cz_q < -PITCH_LIM) begin
      acc_c = 24'(-PITCH_LIM);
    end else begin
      acc_c = cz_q[23:0];
    end

    a_eff = (alpha_i > ALPHA_ONE) ? ALPHA_ONE : alpha_i;
    a_inv = ALPHA_ONE - a_eff;
    inc   = job_q.gyro_y[15] ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
    g     = 30'(pitch_q) + 30'(inc);
    bsum  = 49'(m1_q) + 49'(m2_q) + 49'sd32768;
    bsh   = 33'(bsum >>> 16);
  end

  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    cnt_d    = cnt_q;
    dcnt_d   = dcnt_q;
    sqa_d    = sqa_q;
    rad_d    = rad_q;
    srem_d   = srem_q;
    root_d   = root_q;
    gu_d     = gu_q;
    gpl_d    = gpl_q;
    gph_d    = gph_q;
    gprod_d  = gprod_q;
    dq_d     = dq_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    cz_d     = cz_q;
    acc_d    = acc_q;
    pitch_d  = pitch_q;
    m1_d     = m1_q;
    m2_d     = m2_q;
    ofused_d = ofused_q;
    oacc_d   = oacc_q;
    ovalid_d = ovalid_q && !out_ch.ready;
    stat_o.pop  = 1'b0;
    stat_o.busy = state_q != ST_IDLE;

    if ((state_q == ST_SQRT || state_q == ST_CORD) && dcnt_q != 5'(DIV_STEPS)) begin
      dcnt_d = dcnt_q + 5'd1;
      unique case (dcnt_q)
        5'd0: gpl_d = gu_q[21:0] * GYRO_RECIP;
        5'd1: gph_d = gu_q[43:22] * GYRO_RECIP;
        5'd2: dq_d = gsum[71:44];
        5'd3: gprod_d = 44'(dq_q * GYRO_DEN);
        default: begin
          if (grem >= 44'(GYRO_DEN)) begin
            dq_d = dq_q + 28'd1;
          end
        end
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          stat_o.pop = 1'b1;
          job_d      = q_data_i;
          state_d    = ST_SQA;
        end
      end
      ST_SQA: begin
        sqa_d   = 32'(job_q.accel_y * job_q.accel_y);
        state_d = ST_SQB;
      end
      ST_SQB: begin
        rad_d   = {sq_sum, 16'd0};
        srem_d  = '0;
        root_d  = '0;
        cnt_d   = '0;
        state_d = ST_GYR;
      end
      ST_GYR: begin
        gu_d    = {gmag, 9'd0} + GYRO_RND;
        dcnt_d  = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        srem_d = sge ? sdiff[24:0] : st[24:0];
        root_d = {root_q[22:0], sge};
        rad_d  = {rad_q[45:0], 2'b00};
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'(SQRT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_CORD;
        end
      end
      ST_CORD: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(CSteps - 1)) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        acc_d = acc_c;
        if (job_q.kind == KIND_INIT) begin
          pitch_d = 25'(acc_c);
          state_d = ST_OUT;
        end else begin
          m1_d    = $signed({1'b0, a_eff}) * g;
          state_d = ST_MUL2;
        end
      end
      ST_MUL2: begin
        m2_d    = $signed({1'b0, a_inv}) * acc_q;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (bsh > ANGLE_MAX) begin
          pitch_d = 25'(ANGLE_MAX);
        end else if (bsh < ANGLE_MIN) begin
          pitch_d = 25'(ANGLE_MIN);
        end else begin
          pitch_d = bsh[24:0];
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ofused_d = pitch_q;
          oacc_d   = acc_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (state_q == ST_SQRT && cnt_q == 5'(SQRT_STEPS - 1)) begin
      cx_d = $signed({3'd0, (({root_q[22:0], sge} < DEN_MIN) ? DEN_MIN
                                                            : {root_q[22:0], sge})});
      cy_d = 27'(job_q.accel_x) <<< 8;
      cz_d = '0;
    end else if (state_q == ST_CORD) begin
      if (!cy_q[26]) begin
        cx_d = cx_q + ys;
        cy_d = cy_q - xs;
        cz_d = cz_q + atan_v;
      end else begin
        cx_d = cx_q - ys;
        cy_d = cy_q + xs;
        cz_d = cz_q - atan_v;
      end
    end
  end

  assign out_ch.valid       = ovalid_q;
  assign out_ch.fused_pitch = ofused_q;
  assign out_ch.accel_pitch = oacc_q;

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    cnt_q    <= cnt_d;
    dcnt_q   <= dcnt_d;
    sqa_q    <= sqa_d;
    rad_q    <= rad_d;
    srem_q   <= srem_d;
    root_q   <= root_d;
    gu_q     <= gu_d;
    gpl_q    <= gpl_d;
    gph_q    <= gph_d;
    gprod_q  <= gprod_d;
    dq_q     <= dq_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    cz_q     <= cz_d;
    acc_q    <= acc_d;
    m1_q     <= m1_d;
    m2_q     <= m2_d;
    ofused_q <= ofused_d;
    oacc_q   <= oacc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pitch_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pitch_q  <= pitch_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

@@ rtl/core/imu_pitch_complementary_filter_top.sv @@
// Pitch estimator that fuses accelerometer tilt with the integrated y-axis gyro rate.
// Each input item yields exactly one result item. Items are handled one at a time:
// an update item goes through the square root, the CORDIC stage, two blend multiplies
// and a clamped sum to the output register, an init item skips the multiplies and the
// sum, and a queued item is taken only after the back end has returned to idle. The
// time is set by the bit-serial square root followed by the CORDIC stage (one rotation
// per cycle); the gyro scaling by 1/16.4 LSB/deg/s is a reciprocal multiply with a
// remainder correction that runs alongside the square root. A two-entry queue accepts
// items while the back end works, and the output register holds a result until taken.
// Registers: alpha_q16 at 0x0, max_dt_us at 0x4, fallback_dt_us at 0x8.
module imu_pitch_complementary_filter_top
  import pcf_pkg::*;
#(
  parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcf_in_if.sink      in_ch_i,
  pcf_out_if.source   out_ch_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [16:0] alpha_q;
  logic [19:0] max_dt_q, fb_dt_q;
  logic        wr_en;

  logic           q_push, q_full, q_empty;
  pcf_job_t       q_wdata, q_rdata;
  pcf_back_stat_t back_stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_ALPHA:  prdata = {15'd0, alpha_q};
      REG_MAX_DT: prdata = {12'd0, max_dt_q};
      REG_FB_DT:  prdata = {12'd0, fb_dt_q};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= ALPHA_RST;
      max_dt_q <= MAX_DT_RST;
      fb_dt_q  <= FB_DT_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_ALPHA:  alpha_q  <= pwdata[16:0];
        REG_MAX_DT: max_dt_q <= pwdata[19:0];
        REG_FB_DT:  fb_dt_q  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  pcf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch_i),
    .max_dt_i (max_dt_q),
    .fb_dt_i  (fb_dt_q),
    .q_full_i (q_full),
    .push_o   (q_push),
    .job_o    (q_wdata)
  );

  pcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (back_stat.pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  pcf_back #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .alpha_i   (alpha_q),
    .stat_o    (back_stat),
    .out_ch    (out_ch_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop |-> !q_empty)
    else $error("pop from empty queue");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop |=> back_stat.busy)
    else $error("back end did not start after pop");

  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid |-> (out_ch_o.accel_pitch <= 24'sd5898240 &&
                        out_ch_o.accel_pitch >= -24'sd5898240))
    else $error("accelerometer pitch out of range");

  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch_o.valid) |-> $past(back_stat.busy))
    else $error("result without work");

endmodule
